// ===== src/srq_pkg.sv =====
// Shared constants and types for the sortable ring queue.
package srq_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 2;
	localparam int CAP_W     = 5;
	localparam int CNT_OUT_W = 5;
	localparam int DEPTH_DEF = 16;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_SORT = 2'd2;

	typedef struct packed {
		logic push;
		logic pop;
		logic sort;
		logic phase;
	} cell_ctrl_t;

endpackage

// ===== src/srq_ifs.sv =====
// Request, response and configuration channel interfaces of the sortable ring queue.
interface srq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface srq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] front_value;
	logic               front_valid;
	logic [4:0]         count;
	logic               is_full;
	logic               dropped;

	modport source (output valid, output front_value, output front_valid, output count,
		output is_full, output dropped, input ready);
	modport sink (input valid, input front_value, input front_valid, input count,
		input is_full, input dropped, output ready);
endinterface

interface srq_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/sortable_ring_queue_unit.sv =====
// Top level of the sortable ring queue: a row of entry cells with its control sequencer.
//
// Requests arrive on req_in: operation 0 pushes value at the back, 1 pops the front,
// 2 sorts the held entries ascending (signed) from the front, 3 changes nothing.
// Every request yields exactly one response on rsp_out with the front entry, its
// validity, the count, the full flag and a flag for a push refused on a full queue.
// The capacity register is written on cfg; a write also empties the queue. Values of
// zero are taken as one and values above DEPTH as DEPTH. cfg is always ready and
// holds off req_in while it is valid.
// The entries live in a row of DEPTH cells in queue order. A push loads the cell at
// the current count, a pop shifts every cell one place toward the front, and a sort
// runs DEPTH odd-even exchange phases in which neighboring cells swap in place.
// Push, pop and unused requests are answered by a registered response that appears in
// the cycle after acceptance. A sort runs its exchange phases and then a done state
// before its response is written, during which req_in is not ready.
// The response register holds one response. While it is full and rsp_out is stalled,
// req_in is not ready, so no response is lost. Reset empties the queue, sets the
// capacity to DEPTH and clears the response register.
module sortable_ring_queue_unit #(
	parameter int DEPTH = srq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	srq_req_if.sink   req_in,
	srq_rsp_if.source rsp_out,
	srq_cfg_if.sink   cfg
);
	import srq_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int STEP_W = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic              out_v_q;
	logic [DATA_W-1:0] front_q;
	logic              front_valid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              full_q;
	logic              dropped_q;

	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic              swap_r [DEPTH];

	logic              slot_free;
	logic              req_fire;
	logic              rsp_load;
	logic              do_push;
	logic              do_pop;
	logic [CNT_W-1:0]  count_nx;
	logic [DATA_W-1:0] front_nx;
	logic              drop_nx;
	logic [31:0]       raw_cap;
	logic [CNT_W-1:0]  cap_nx;

	assign slot_free    = !out_v_q || rsp_out.ready;
	assign req_in.ready = (state_q == ST_IDLE) && slot_free && !cfg.valid;
	assign req_fire     = req_in.valid && req_in.ready;
	assign cfg.ready    = 1'b1;

	assign rsp_load = (req_fire && (req_in.operation != OP_SORT)) ||
		((state_q == ST_DONE) && slot_free);

	assign do_push = req_fire && (req_in.operation == OP_PUSH) && (count_q < cap_q);
	assign do_pop  = req_fire && (req_in.operation == OP_POP) && (count_q != '0);

	assign ctrl.push  = do_push;
	assign ctrl.pop   = do_pop;
	assign ctrl.sort  = (state_q == ST_SORT);
	assign ctrl.phase = step_q[0];

	assign raw_cap = 32'(cfg.data);
	assign cap_nx  = (raw_cap == 32'd0) ? CNT_W'(1) :
		((raw_cap > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(raw_cap));

	always_comb begin
		count_nx = count_q;
		front_nx = (count_q != '0) ? cell_data[0] : '0;
		drop_nx  = 1'b0;
		if (do_push) begin
			count_nx = count_q + CNT_W'(1);
			front_nx = (count_q == '0) ? DATA_W'(req_in.value) : cell_data[0];
		end else if (do_pop) begin
			count_nx = count_q - CNT_W'(1);
			front_nx = (count_q > CNT_W'(1)) ? cell_data[1] : '0;
		end else if (req_fire && (req_in.operation == OP_PUSH)) begin
			drop_nx = 1'b1;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [DATA_W-1:0] left_d;
			logic [DATA_W-1:0] right_d;
			logic              swap_l;

			if (gi == 0) begin : g_first
				assign left_d = cell_data[gi];
				assign swap_l = 1'b0;
			end else begin : g_inner_l
				assign left_d = cell_data[gi-1];
				assign swap_l = swap_r[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign right_d = cell_data[gi];
			end else begin : g_inner_r
				assign right_d = cell_data[gi+1];
			end

			srq_cell #(
				.CNT_W(CNT_W),
				.IDX  (gi)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.count     (count_q),
				.value     (DATA_W'(req_in.value)),
				.left_data (left_d),
				.right_data(right_d),
				.swap_left (swap_l),
				.swap_right(swap_r[gi]),
				.data      (cell_data[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			count_q       <= '0;
			cap_q         <= CNT_W'(DEPTH);
			out_v_q       <= 1'b0;
			front_q       <= '0;
			front_valid_q <= 1'b0;
			out_count_q   <= '0;
			full_q        <= 1'b0;
			dropped_q     <= 1'b0;
		end else begin
			if (out_v_q && rsp_out.ready && !rsp_load) begin
				out_v_q <= 1'b0;
			end
			if (cfg.valid) begin
				cap_q   <= cap_nx;
				count_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req_in.operation == OP_SORT) begin
							state_q <= ST_SORT;
							step_q  <= '0;
						end else begin
							count_q       <= count_nx;
							out_v_q       <= 1'b1;
							front_q       <= front_nx;
							front_valid_q <= (count_nx != '0);
							out_count_q   <= count_nx;
							full_q        <= (count_nx == cap_q);
							dropped_q     <= drop_nx;
						end
					end
				end
				ST_SORT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DEPTH - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q       <= ST_IDLE;
						out_v_q       <= 1'b1;
						front_q       <= (count_q != '0) ? cell_data[0] : '0;
						front_valid_q <= (count_q != '0);
						out_count_q   <= count_q;
						full_q        <= (count_q == cap_q);
						dropped_q     <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_out.valid       = out_v_q;
	assign rsp_out.front_value = front_q;
	assign rsp_out.front_valid = front_valid_q;
	assign rsp_out.count       = CNT_OUT_W'(out_count_q);
	assign rsp_out.is_full     = full_q;
	assign rsp_out.dropped     = dropped_q;

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("Entry count exceeds the capacity in use.");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_in.ready)
		else $error("Request accepted while a sort is in progress.");

	a_drop_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && dropped_q) |-> full_q)
		else $error("Dropped push reported on a queue that is not full.");

	a_front_valid_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (front_valid_q == (out_count_q != '0)))
		else $error("Front validity disagrees with the reported count.");

endmodule

// ===== src/srq_cell.sv =====
// One queue cell holding a single entry, with push, pop shift and sort exchange.
module srq_cell #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic                      clk,
	input  srq_pkg::cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0]          count,
	input  logic [srq_pkg::DATA_W-1:0] value,
	input  logic [srq_pkg::DATA_W-1:0] left_data,
	input  logic [srq_pkg::DATA_W-1:0] right_data,
	input  logic                      swap_left,
	output logic                      swap_right,
	output logic [srq_pkg::DATA_W-1:0] data
);
	import srq_pkg::*;

	localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic PAIR_PHASE = 1'(IDX % 2);

	logic [DATA_W-1:0] data_q;
	logic              right_used;
	logic              greater;

	// The right neighbor takes part in the sort only while it holds an entry.
	assign right_used = (CNT_W'(IDX + 1) < count);
	assign greater    = ((data_q ^ SIGN_FLIP) > (right_data ^ SIGN_FLIP));
	assign swap_right = ctrl.sort && (ctrl.phase == PAIR_PHASE) && right_used && greater;
	assign data       = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push && (count == CNT_W'(IDX))) begin
			data_q <= value;
		end else if (ctrl.pop) begin
			data_q <= right_data;
		end else if (swap_right) begin
			data_q <= right_data;
		end else if (swap_left) begin
			data_q <= left_data;
		end
	end

endmodule

// ===== sim/sortable_ring_queue_unit_test.sv =====
// Self-checking testbench for the sortable ring queue: random push, pop and sort traffic.
`timescale 1ns / 1ps

module sortable_ring_queue_unit_test;
	import srq_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [OP_W-1:0]          operation;
		logic signed [DATA_W-1:0] value;
	} request_t;

	typedef struct {
		logic signed [DATA_W-1:0] front_value;
		logic                     front_valid;
		logic [CNT_OUT_W-1:0]     count;
		logic                     is_full;
		logic                     dropped;
	} status_t;

	logic clk;
	logic arst_n;

	srq_req_if req_ch ();
	srq_rsp_if rsp_ch ();
	srq_cfg_if cfg_ch ();

	sortable_ring_queue_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_in  (req_ch),
		.rsp_out (rsp_ch),
		.cfg     (cfg_ch)
	);

	request_t                 pending_requests[$];
	request_t                 in_flight;
	status_t                  awaited_status[$];
	logic signed [DATA_W-1:0] queue_contents[$];
	int                       capacity_limit;
	int                       gap_left;
	int                       stall_left;
	int                       mismatches;
	int                       requests_done;
	int                       responses_seen;
	int                       sorts_seen;
	int                       drops_seen;
	int                       capacity_writes;
	int                       cycle_count;
	bit                       quiet;

	function automatic status_t predict_status(request_t r);
		status_t                  s;
		logic signed [DATA_W-1:0] key;
		int                       j;
		s.dropped = 1'b0;
		case (r.operation)
			OP_PUSH: begin
				if (queue_contents.size() >= capacity_limit) begin
					s.dropped = 1'b1;
					drops_seen++;
				end else begin
					queue_contents.push_back(r.value);
				end
			end
			OP_POP: begin
				if (queue_contents.size() != 0)
					void'(queue_contents.pop_front());
			end
			OP_SORT: begin
				sorts_seen++;
				for (int i = 1; i < queue_contents.size(); i++) begin
					key = queue_contents[i];
					j = i;
					while (j > 0 && queue_contents[j-1] > key) begin
						queue_contents[j] = queue_contents[j-1];
						j--;
					end
					queue_contents[j] = key;
				end
			end
			default: begin
			end
		endcase
		s.front_valid = queue_contents.size() != 0;
		s.front_value = (queue_contents.size() != 0) ? queue_contents[0] : '0;
		s.count = CNT_OUT_W'(queue_contents.size());
		s.is_full = queue_contents.size() == capacity_limit;
		return s;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d responses awaited.", cycle_count,
				awaited_status.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				awaited_status.push_back(predict_status(in_flight));
				requests_done++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (!quiet && gap_left == 0 && $urandom_range(0, 9) == 0)
					gap_left = $urandom_range(1, 15);
				if (gap_left != 0 || pending_requests.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					req_ch.valid <= 1'b0;
				end else begin
					in_flight = pending_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= in_flight.operation;
					req_ch.value <= in_flight.value;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				responses_seen++;
				if (awaited_status.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("Unexpected response: front %0d valid %0b count %0d",
							rsp_ch.front_value, rsp_ch.front_valid, rsp_ch.count);
				end else begin
					status_t e;
					e = awaited_status.pop_front();
					if (rsp_ch.front_value !== e.front_value
							|| rsp_ch.front_valid !== e.front_valid
							|| rsp_ch.count !== e.count || rsp_ch.is_full !== e.is_full
							|| rsp_ch.dropped !== e.dropped) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("Mismatch on response %0d: expected %0d/%0b/%0d/%0b/%0b, %s %0d/%0b/%0d/%0b/%0b",
								responses_seen, e.front_value, e.front_valid, e.count,
								e.is_full, e.dropped, "got", rsp_ch.front_value,
								rsp_ch.front_valid, rsp_ch.count, rsp_ch.is_full,
								rsp_ch.dropped);
					end
				end
			end
			if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 15);
			if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic add_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
		request_t r;
		r.operation = op;
		r.value = val;
		pending_requests.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending_requests.size() != 0 || req_ch.valid || awaited_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= cap;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		queue_contents.delete();
		capacity_limit = (cap == 0) ? 1 : ((cap > DEPTH_DEF) ? DEPTH_DEF : int'(cap));
		capacity_writes++;
	endtask

	task automatic add_random_requests(int n, int push_weight);
		int                       pick;
		logic signed [DATA_W-1:0] val;
		logic [OP_W-1:0]          op;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < push_weight)
				op = OP_PUSH;
			else if (pick < 88)
				op = OP_POP;
			else if (pick < 97)
				op = OP_SORT;
			else
				op = OP_NONE;
			case ($urandom_range(0, 5))
				0: begin
					case ($urandom_range(0, 3))
						0: val = 32'sh8000_0000;
						1: val = 32'sh7fff_ffff;
						2: val = 32'sh0000_0000;
						default: val = -32'sd1;
					endcase
				end
				1, 2: val = $signed(32'($urandom_range(0, 16))) - 32'sd8;
				default: val = $signed($urandom);
			endcase
			add_request(op, val);
		end
	endtask

	initial begin
		int push_weights[3];
		logic [CAP_W-1:0] caps[8];
		push_weights = '{30, 55, 75};
		req_ch.valid = 1'b0;
		req_ch.operation = OP_PUSH;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		capacity_limit = DEPTH_DEF;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		add_request(OP_POP, 32'sd5);
		add_request(OP_SORT, 32'sd0);
		add_request(OP_NONE, -32'sd1);
		add_request(OP_PUSH, 32'sh8000_0000);
		add_request(OP_SORT, 32'sd0);
		add_request(OP_PUSH, 32'sh7fff_ffff);
		add_request(OP_PUSH, -32'sd1);
		add_request(OP_PUSH, 32'sd0);
		add_request(OP_PUSH, 32'sd1);
		add_request(OP_PUSH, -32'sd1);
		add_request(OP_SORT, 32'sd0);
		add_request(OP_POP, 32'sd0);
		add_request(OP_POP, 32'sd0);
		add_request(OP_NONE, 32'sh5555_aaaa);
		write_capacity(5'd2);
		add_request(OP_PUSH, 32'sd9);
		add_request(OP_PUSH, -32'sd9);
		add_request(OP_PUSH, 32'sd3);
		add_request(OP_SORT, 32'sd0);
		add_request(OP_NONE, 32'sd0);
		add_request(OP_POP, 32'sd0);
		add_request(OP_POP, 32'sd0);
		add_request(OP_POP, 32'sd0);

		caps = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd7, 5'($urandom_range(2, 15)),
			5'($urandom_range(2, 31))};
		for (int p = 0; p < 8; p++) begin
			write_capacity(caps[p]);
			if (p == 7)
				quiet = 1'b1;
			add_random_requests(54, push_weights[p % 3]);
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (awaited_status.size() != 0)
			mismatches++;
		$display("Ran %0d requests under %0d capacity writes; %0d sorts and %0d refused pushes.",
			requests_done, capacity_writes, sorts_seen, drops_seen);
		$display("Responses checked: %0d, mismatches: %0d.", responses_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/srq_pkg.sv
src/srq_ifs.sv
src/srq_cell.sv
src/sortable_ring_queue_unit.sv
sim/sortable_ring_queue_unit_test.sv
